@@ rtl/bsm_pkg.sv @@
// Shared widths, payload structs and queue sizing for the bounding sphere merge core.
// Used by every module under rtl/; depends on nothing.
package bsm_pkg;

    // Coordinate width; radii are one bit narrower
    localparam int COORD_WIDTH = 32;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    // Absolute centre offset needs one more bit than a coordinate
    localparam int OFF_WIDTH   = COORD_WIDTH + 1;
    // Squared distance, sum of three offset squares
    localparam int DIST_WIDTH  = 2 * OFF_WIDTH;
    // Integer square root of the squared distance
    localparam int ROOT_WIDTH  = OFF_WIDTH;
    // Shared multiplier size, split into two halves
    localparam int MUL_WIDTH   = OFF_WIDTH + 1;
    localparam int MUL_HALF    = MUL_WIDTH / 2;
    localparam int MUL_OUT     = 2 * MUL_WIDTH;
    // Signed width of a moved centre before clipping
    localparam int MOVE_WIDTH  = COORD_WIDTH + 2;

    // Fixed port field widths
    localparam int X_W        = 32;
    localparam int R_W        = 31;
    localparam int GROWTH_W   = 62;
    localparam int S_TDATA_W  = 256;
    localparam int M_TDATA_W  = 192;
    localparam int M_TUSER_W  = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One accepted sphere pair
    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] c1;
        logic [2:0][COORD_WIDTH-1:0] c2;
        logic [RAD_WIDTH-1:0]        r1;
        logic [RAD_WIDTH-1:0]        r2;
    } in_t;

    // Front payload while the squares are formed
    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] c1;
        logic [2:0][COORD_WIDTH-1:0] c2;
        logic [2:0][OFF_WIDTH-1:0]   off;
        logic [2:0]                  neg;
        logic [RAD_WIDTH-1:0]        r1;
        logic [RAD_WIDTH-1:0]        r2;
        logic                        pick_one;
    } front_t;

    // Classified pair handed to the back
    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] base;
        logic [2:0][OFF_WIDTH-1:0]   off;
        logic [2:0]                  neg;
        logic [RAD_WIDTH-1:0]        r1;
        logic [RAD_WIDTH-1:0]        r2;
        logic                        pick_one;
        logic                        enclosed;
        logic                        overlap;
    } item_t;

    typedef struct packed {
        item_t                 item;
        logic [DIST_WIDTH-1:0] dist2;
    } queue_t;

    // Finished merge
    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] center;
        logic [RAD_WIDTH-1:0]        radius;
        logic [GROWTH_W-1:0]         growth;
        logic                        overlap;
        logic                        enclosed;
        logic                        saturated;
    } out_t;

endpackage

@@ rtl/bounding_sphere_merge_core.sv @@
// Channel    Dir  Handshake         Payload
// s_ (pair)  in   s_tvalid/tready   one x,y,z,radius then two x,y,z,radius
// m_ (merge) out  m_tvalid/tready   merged x,y,z,radius,growth; flags in tuser
//
// One sphere pair per cycle while the queue has room, results in order. A
// pair passes from the accepting edge through 3 front stages, the queue,
// 33 square root stages, radius, 2 multiply stages, 33 divide stages and
// the output register.
// Reset (aresetn low, synchronous) empties all stages and the queue.
// A stalled m_ side holds the back end; the front keeps taking pairs until
// the four-entry queue fills, then drops s_tready.
//
// Top level of the bounding sphere merge; depends on bsm_pkg, bsm_front,
// bsm_queue and bsm_back.
module bounding_sphere_merge_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // one_x, one_y, one_z, one_radius, two_x, two_y, two_z, two_radius, zero pad
    input  logic [bsm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // merged_x, merged_y, merged_z, merged_radius, growth, zero pad
    output logic [bsm_pkg::M_TDATA_W-1:0]   m_tdata,
    // overlap, enclosed, saturated
    output logic [bsm_pkg::M_TUSER_W-1:0]   m_tuser
);

    bsm_pkg::in_t    in_data;
    bsm_pkg::queue_t push_data, head;
    bsm_pkg::out_t   res;
    logic            push, pop, full, empty;

    // Unpack the request
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_data.c1[k] = s_tdata[k*bsm_pkg::X_W +: bsm_pkg::COORD_WIDTH];
            in_data.c2[k] = s_tdata[127 + k*bsm_pkg::X_W +: bsm_pkg::COORD_WIDTH];
        end
        in_data.r1 = s_tdata[96 +: bsm_pkg::RAD_WIDTH];
        in_data.r2 = s_tdata[223 +: bsm_pkg::RAD_WIDTH];
    end

    bsm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (in_data),
        .q_push   (push),
        .q_data   (push_data),
        .q_full   (full)
    );

    bsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    bsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (!empty),
        .q_data    (head),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Pack the result
    assign m_tdata = {3'b000,
                      res.growth,
                      bsm_pkg::R_W'(res.radius),
                      bsm_pkg::X_W'($signed(res.center[2])),
                      bsm_pkg::X_W'($signed(res.center[1])),
                      bsm_pkg::X_W'($signed(res.center[0]))};
    assign m_tuser = {res.saturated, res.enclosed, res.overlap};

endmodule

@@ rtl/bsm_mul.sv @@
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on bsm_pkg for its widths.
module bsm_mul (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [bsm_pkg::MUL_WIDTH-1:0] a,
    input  logic [bsm_pkg::MUL_WIDTH-1:0] b,
    output logic [bsm_pkg::MUL_OUT-1:0]   p
);

    logic [bsm_pkg::MUL_WIDTH-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [bsm_pkg::MUL_OUT-1:0]   p_reg, p_next;

    // Stage one: partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a[bsm_pkg::MUL_HALF-1:0] * b[bsm_pkg::MUL_HALF-1:0];
            lh_reg <= a[bsm_pkg::MUL_HALF-1:0] * b[bsm_pkg::MUL_WIDTH-1:bsm_pkg::MUL_HALF];
            hl_reg <= a[bsm_pkg::MUL_WIDTH-1:bsm_pkg::MUL_HALF] * b[bsm_pkg::MUL_HALF-1:0];
            hh_reg <= a[bsm_pkg::MUL_WIDTH-1:bsm_pkg::MUL_HALF]
                      * b[bsm_pkg::MUL_WIDTH-1:bsm_pkg::MUL_HALF];
        end
    end

    // Stage two: aligned sum
    always_comb begin
        p_next = (bsm_pkg::MUL_OUT'(hh_reg) << bsm_pkg::MUL_WIDTH)
               + ((bsm_pkg::MUL_OUT'(lh_reg) + bsm_pkg::MUL_OUT'(hl_reg)) << bsm_pkg::MUL_HALF)
               + bsm_pkg::MUL_OUT'(ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/bsm_front.sv @@
// Front end: takes sphere pairs, forms offsets and squared distance, classifies
// each pair as enclosed or not and as overlapping or not. Depends on bsm_pkg and bsm_mul.
module bsm_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bsm_pkg::in_t    in_data,
    output logic            q_push,
    output bsm_pkg::queue_t q_data,
    input  logic            q_full
);

    logic            f0_valid_reg, f1_valid_reg, f2_valid_reg;
    bsm_pkg::in_t    f0_reg;
    bsm_pkg::front_t f1_reg, f2_reg, f0_front;
    logic            adv;

    logic [bsm_pkg::RAD_WIDTH-1:0] rd;
    logic [bsm_pkg::RAD_WIDTH:0]   rs;
    logic [2:0][bsm_pkg::MUL_OUT-1:0] p_off;
    logic [bsm_pkg::MUL_OUT-1:0]   p_rd, p_rs;
    logic [bsm_pkg::DIST_WIDTH-1:0] dist2;
    logic                          enclosed, overlap;

    // Whole front holds only when its last stage cannot drain
    assign adv      = !(f2_valid_reg && q_full);
    assign in_ready = adv;
    assign q_push   = f2_valid_reg && adv;

    // Offsets and radius sum/difference from the input register
    always_comb begin
        logic signed [bsm_pkg::OFF_WIDTH-1:0] diff;
        f0_front.c1       = f0_reg.c1;
        f0_front.c2       = f0_reg.c2;
        f0_front.r1       = f0_reg.r1;
        f0_front.r2       = f0_reg.r2;
        f0_front.pick_one = f0_reg.r1 > f0_reg.r2;
        for (int k = 0; k < 3; k++) begin
            diff = bsm_pkg::OFF_WIDTH'($signed(f0_reg.c2[k]))
                 - bsm_pkg::OFF_WIDTH'($signed(f0_reg.c1[k]));
            f0_front.neg[k] = diff[bsm_pkg::OFF_WIDTH-1];
            f0_front.off[k] = diff[bsm_pkg::OFF_WIDTH-1] ? -diff : diff;
        end
        rd = f0_front.pick_one ? (f0_reg.r1 - f0_reg.r2) : (f0_reg.r2 - f0_reg.r1);
        rs = (bsm_pkg::RAD_WIDTH+1)'(f0_reg.r1) + (bsm_pkg::RAD_WIDTH+1)'(f0_reg.r2);
    end

    for (genvar k = 0; k < 3; k++) begin : g_sq
        bsm_mul u_mul (
            .aclk (aclk),
            .en   (adv),
            .a    (bsm_pkg::MUL_WIDTH'(f0_front.off[k])),
            .b    (bsm_pkg::MUL_WIDTH'(f0_front.off[k])),
            .p    (p_off[k])
        );
    end

    bsm_mul u_mul_rd (
        .aclk (aclk),
        .en   (adv),
        .a    (bsm_pkg::MUL_WIDTH'(rd)),
        .b    (bsm_pkg::MUL_WIDTH'(rd)),
        .p    (p_rd)
    );

    bsm_mul u_mul_rs (
        .aclk (aclk),
        .en   (adv),
        .a    (bsm_pkg::MUL_WIDTH'(rs)),
        .b    (bsm_pkg::MUL_WIDTH'(rs)),
        .p    (p_rs)
    );

    // Pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (adv) begin
            f0_valid_reg <= in_valid;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f0_reg <= in_data;
            f1_reg <= f0_front;
            f2_reg <= f1_reg;
        end
    end

    // Classification once the squares are in
    always_comb begin
        dist2 = bsm_pkg::DIST_WIDTH'(p_off[0]) + bsm_pkg::DIST_WIDTH'(p_off[1])
              + bsm_pkg::DIST_WIDTH'(p_off[2]);
        enclosed = bsm_pkg::MUL_OUT'(dist2) <= p_rd;
        overlap  = !(p_rs <= bsm_pkg::MUL_OUT'(dist2));
        for (int k = 0; k < 3; k++) begin
            q_data.item.base[k] = (enclosed && !f2_reg.pick_one) ? f2_reg.c2[k] : f2_reg.c1[k];
        end
        q_data.item.off      = f2_reg.off;
        q_data.item.neg      = f2_reg.neg;
        q_data.item.r1       = f2_reg.r1;
        q_data.item.r2       = f2_reg.r2;
        q_data.item.pick_one = f2_reg.pick_one;
        q_data.item.enclosed = enclosed;
        q_data.item.overlap  = overlap;
        q_data.dist2         = dist2;
    end

endmodule

@@ rtl/bsm_queue.sv @@
// Short flop queue between the front end and the back end.
// Depends on bsm_pkg for the entry type and depth.
module bsm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bsm_pkg::queue_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output bsm_pkg::queue_t head
);

    bsm_pkg::queue_t               mem_reg [bsm_pkg::QUEUE_DEPTH];
    logic [bsm_pkg::QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [bsm_pkg::QUEUE_CW-1:0]  count_reg, count_next;

    assign full  = count_reg == bsm_pkg::QUEUE_CW'(bsm_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/bsm_back.sv @@
// Back end: pipelined square root, radius, centre move products, pipelined
// divides, clipping and the output register. Depends on bsm_pkg and bsm_mul.
module bsm_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  bsm_pkg::queue_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output bsm_pkg::out_t   out_data
);

    localparam int RW = bsm_pkg::ROOT_WIDTH;
    localparam int OW = bsm_pkg::OFF_WIDTH;
    localparam int DW = bsm_pkg::DIST_WIDTH;
    localparam int TW = bsm_pkg::DIST_WIDTH + 1;

    logic adv;

    // Square root stages, one root bit each
    logic            sq_valid_reg [RW];
    bsm_pkg::item_t  sq_item_reg  [RW];
    logic [DW-1:0]   sq_rem_reg   [RW];
    logic [RW-1:0]   sq_root_reg  [RW];

    // Radius stage
    logic                          r_valid_reg;
    bsm_pkg::item_t                r_item_reg;
    logic [RW-1:0]                 r_d_reg, r_k_reg;
    logic [bsm_pkg::RAD_WIDTH-1:0] r_rout_reg;
    logic                          r_sat_reg;

    // Stages alongside the multipliers
    logic                          m_valid_reg [2];
    bsm_pkg::item_t                m_item_reg  [2];
    logic [RW-1:0]                 m_d_reg     [2];
    logic [bsm_pkg::RAD_WIDTH-1:0] m_rout_reg  [2];
    logic                          m_sat_reg   [2];
    logic [2:0][bsm_pkg::MUL_OUT-1:0] p_move;
    logic [bsm_pkg::MUL_OUT-1:0]      p_rr, p_r1;

    // Divide stages, one quotient bit each, three lanes
    logic                          dv_valid_reg  [OW];
    bsm_pkg::item_t                dv_item_reg   [OW];
    logic [RW-1:0]                 dv_d_reg      [OW];
    logic [bsm_pkg::RAD_WIDTH-1:0] dv_rout_reg   [OW];
    logic                          dv_sat_reg    [OW];
    logic [bsm_pkg::GROWTH_W-1:0]  dv_growth_reg [OW];
    logic [2:0][RW-1:0]            dv_rem_reg    [OW];
    logic [2:0][OW-1:0]            dv_w_reg      [OW];

    logic          o_valid_reg;
    bsm_pkg::out_t o_reg, o_next;

    // Everything moves together while the output slot can drain
    assign adv       = !o_valid_reg || out_ready;
    assign q_pop     = adv && q_valid;
    assign out_valid = o_valid_reg;
    assign out_data  = o_reg;

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        localparam int B = RW - 1 - i;
        logic           valid_in;
        bsm_pkg::item_t item_in;
        logic [DW-1:0]  rem_in;
        logic [RW-1:0]  root_in;
        logic [TW-1:0]  trial, rem_ext, rem_sub;
        logic           take;

        if (i == 0) begin : g_head
            assign valid_in = q_valid;
            assign item_in  = q_data.item;
            assign rem_in   = q_data.dist2;
            assign root_in  = '0;
        end else begin : g_link
            assign valid_in = sq_valid_reg[i-1];
            assign item_in  = sq_item_reg[i-1];
            assign rem_in   = sq_rem_reg[i-1];
            assign root_in  = sq_root_reg[i-1];
        end

        // (root + 2^B)^2 - root^2 against the remainder
        assign trial   = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
        assign rem_ext = TW'(rem_in);
        assign take    = rem_ext >= trial;
        assign rem_sub = rem_ext - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[i] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_item_reg[i] <= item_in;
                sq_rem_reg[i]  <= take ? rem_sub[DW-1:0] : rem_in;
                sq_root_reg[i] <= root_in | (RW'(take) << B);
            end
        end
    end

    // New radius, move numerator factor and clipped radius
    always_ff @(posedge aclk) begin
        logic [RW:0]                   rsum;
        logic [RW-1:0]                 rfull, d;
        bsm_pkg::item_t                it;
        logic                          over;
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (adv) begin
            r_valid_reg <= sq_valid_reg[RW-1];
        end
        it    = sq_item_reg[RW-1];
        d     = sq_root_reg[RW-1];
        rsum  = (RW+1)'(d) + (RW+1)'(it.r1) + (RW+1)'(it.r2);
        rfull = rsum[RW:1];
        over  = rfull > RW'({bsm_pkg::RAD_WIDTH{1'b1}});
        if (adv) begin
            r_item_reg <= it;
            r_d_reg    <= d;
            r_k_reg    <= rfull - RW'(it.r1);
            if (it.enclosed) begin
                r_rout_reg <= it.pick_one ? it.r1 : it.r2;
                r_sat_reg  <= 1'b0;
            end else begin
                r_rout_reg <= over ? {bsm_pkg::RAD_WIDTH{1'b1}} : rfull[bsm_pkg::RAD_WIDTH-1:0];
                r_sat_reg  <= over;
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_move
        bsm_mul u_mul (
            .aclk (aclk),
            .en   (adv),
            .a    (bsm_pkg::MUL_WIDTH'(r_item_reg.off[k])),
            .b    (bsm_pkg::MUL_WIDTH'(r_k_reg)),
            .p    (p_move[k])
        );
    end

    bsm_mul u_mul_rr (
        .aclk (aclk),
        .en   (adv),
        .a    (bsm_pkg::MUL_WIDTH'(r_rout_reg)),
        .b    (bsm_pkg::MUL_WIDTH'(r_rout_reg)),
        .p    (p_rr)
    );

    bsm_mul u_mul_r1 (
        .aclk (aclk),
        .en   (adv),
        .a    (bsm_pkg::MUL_WIDTH'(r_item_reg.r1)),
        .b    (bsm_pkg::MUL_WIDTH'(r_item_reg.r1)),
        .p    (p_r1)
    );

    // Payload beside the multipliers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg[0] <= 1'b0;
            m_valid_reg[1] <= 1'b0;
        end else if (adv) begin
            m_valid_reg[0] <= r_valid_reg;
            m_valid_reg[1] <= m_valid_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_item_reg[0] <= r_item_reg;
            m_d_reg[0]    <= r_d_reg;
            m_rout_reg[0] <= r_rout_reg;
            m_sat_reg[0]  <= r_sat_reg;
            m_item_reg[1] <= m_item_reg[0];
            m_d_reg[1]    <= m_d_reg[0];
            m_rout_reg[1] <= m_rout_reg[0];
            m_sat_reg[1]  <= m_sat_reg[0];
        end
    end

    for (genvar j = 0; j < OW; j++) begin : g_div
        logic                          valid_in;
        bsm_pkg::item_t                item_in;
        logic [RW-1:0]                 d_in;
        logic [bsm_pkg::RAD_WIDTH-1:0] rout_in;
        logic                          sat_in;
        logic [bsm_pkg::GROWTH_W-1:0]  growth_in;
        logic [2:0][RW-1:0]            rem_in, rem_out;
        logic [2:0][OW-1:0]            w_in, w_out;

        if (j == 0) begin : g_head
            assign valid_in  = m_valid_reg[1];
            assign item_in   = m_item_reg[1];
            assign d_in      = m_d_reg[1];
            assign rout_in   = m_rout_reg[1];
            assign sat_in    = m_sat_reg[1];
            assign growth_in = p_rr[bsm_pkg::GROWTH_W-1:0] - p_r1[bsm_pkg::GROWTH_W-1:0];
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign rem_in[k] = p_move[k][OW+RW-1:OW];
                assign w_in[k]   = p_move[k][OW-1:0];
            end
        end else begin : g_link
            assign valid_in  = dv_valid_reg[j-1];
            assign item_in   = dv_item_reg[j-1];
            assign d_in      = dv_d_reg[j-1];
            assign rout_in   = dv_rout_reg[j-1];
            assign sat_in    = dv_sat_reg[j-1];
            assign growth_in = dv_growth_reg[j-1];
            assign rem_in    = dv_rem_reg[j-1];
            assign w_in      = dv_w_reg[j-1];
        end

        // Restoring step: next numerator bit in, quotient bit out
        always_comb begin
            logic [RW:0] remsh, remsub;
            logic        ge;
            for (int k = 0; k < 3; k++) begin
                remsh      = {rem_in[k], w_in[k][OW-1]};
                remsub     = remsh - (RW+1)'(d_in);
                ge         = remsh >= (RW+1)'(d_in);
                rem_out[k] = ge ? remsub[RW-1:0] : remsh[RW-1:0];
                w_out[k]   = {w_in[k][OW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_item_reg[j]   <= item_in;
                dv_d_reg[j]      <= d_in;
                dv_rout_reg[j]   <= rout_in;
                dv_sat_reg[j]    <= sat_in;
                dv_growth_reg[j] <= growth_in;
                dv_rem_reg[j]    <= rem_out;
                dv_w_reg[j]      <= w_out;
            end
        end
    end

    // Move the centre and clip to the coordinate range
    always_comb begin
        logic signed [bsm_pkg::MOVE_WIDTH-1:0] v, m, cmax, cmin;
        bsm_pkg::item_t                        it;
        logic                                  sat;
        it   = dv_item_reg[OW-1];
        sat  = dv_sat_reg[OW-1];
        cmax = bsm_pkg::MOVE_WIDTH'({1'b0, {(bsm_pkg::COORD_WIDTH-1){1'b1}}});
        cmin = -cmax - bsm_pkg::MOVE_WIDTH'(1);
        for (int k = 0; k < 3; k++) begin
            m = $signed(bsm_pkg::MOVE_WIDTH'(dv_w_reg[OW-1][k]));
            v = bsm_pkg::MOVE_WIDTH'($signed(it.base[k]));
            if (!it.enclosed) begin
                v = it.neg[k] ? (v - m) : (v + m);
            end
            if (v > cmax) begin
                v   = cmax;
                sat = 1'b1;
            end else if (v < cmin) begin
                v   = cmin;
                sat = 1'b1;
            end
            o_next.center[k] = v[bsm_pkg::COORD_WIDTH-1:0];
        end
        o_next.radius    = dv_rout_reg[OW-1];
        o_next.growth    = dv_growth_reg[OW-1];
        o_next.overlap   = it.overlap;
        o_next.enclosed  = it.enclosed;
        o_next.saturated = sat;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            o_valid_reg <= dv_valid_reg[OW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_reg <= o_next;
        end
    end

endmodule
